FILE: sv/scabf_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scabf_pkg
// Types and constants shared by the six-channel alpha-beta filter.
// ---------------------------------------------------------------------------
package scabf_pkg;

   localparam int POS_W     = 40;
   localparam int VEL_W     = 48;
   localparam int STATE_W   = POS_W + VEL_W;
   localparam int DT_W      = 16;
   localparam int SAMPLE_W  = 16;
   localparam int CHAN_W    = 3;
   localparam int ALPHA_W   = 17;
   localparam int BETA_W    = 25;
   localparam int DIV_NUM_W = 56;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;
   localparam logic [BETA_W-1:0]  BETA_ONE  = 25'd16777216;

   localparam logic [ALPHA_W-1:0] ALPHA_ACCEL_RST = 17'd32768;
   localparam logic [BETA_W-1:0]  BETA_ACCEL_RST  = 25'd16777;
   localparam logic [ALPHA_W-1:0] ALPHA_GYRO_RST  = 17'd42598;
   localparam logic [BETA_W-1:0]  BETA_GYRO_RST   = 25'd150995;

   localparam logic [1:0] REG_ALPHA_ACCEL = 2'd0;
   localparam logic [1:0] REG_BETA_ACCEL  = 2'd1;
   localparam logic [1:0] REG_ALPHA_GYRO  = 2'd2;
   localparam logic [1:0] REG_BETA_GYRO   = 2'd3;

   typedef struct packed {
      logic [ALPHA_W-1:0] alpha_accel;
      logic [BETA_W-1:0]  beta_accel;
      logic [ALPHA_W-1:0] alpha_gyro;
      logic [BETA_W-1:0]  beta_gyro;
   } gains_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_PRED_LO,
      ST_PRED_HI,
      ST_PRED,
      ST_RESID,
      ST_POS_LO,
      ST_POS_HI,
      ST_POS,
      ST_BETA_LO,
      ST_BETA_HI,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_VEL,
      ST_DONE
   } state_type;

endpackage

FILE: sv/scabf_csr.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scabf_csr
// Gain registers behind the configuration port.
// ---------------------------------------------------------------------------
module scabf_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [scabf_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [scabf_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [scabf_pkg::CSR_DATA_W-1:0] prdata,
   output logic                             pready,
   output scabf_pkg::gains_type             gains
);
   import scabf_pkg::*;

   gains_type  gains_ff;
   logic [1:0] reg_idx;
   logic       wr_en;

   assign reg_idx = paddr[3:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign gains   = gains_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.alpha_accel <= ALPHA_ACCEL_RST;
         gains_ff.beta_accel  <= BETA_ACCEL_RST;
         gains_ff.alpha_gyro  <= ALPHA_GYRO_RST;
         gains_ff.beta_gyro   <= BETA_GYRO_RST;
      end else if (wr_en) begin
         case (reg_idx)
            REG_ALPHA_ACCEL: gains_ff.alpha_accel <= pwdata[ALPHA_W-1:0];
            REG_BETA_ACCEL:  gains_ff.beta_accel  <= pwdata[BETA_W-1:0];
            REG_ALPHA_GYRO:  gains_ff.alpha_gyro  <= pwdata[ALPHA_W-1:0];
            REG_BETA_GYRO:   gains_ff.beta_gyro   <= pwdata[BETA_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_ALPHA_ACCEL: prdata = CSR_DATA_W'(gains_ff.alpha_accel);
         REG_BETA_ACCEL:  prdata = CSR_DATA_W'(gains_ff.beta_accel);
         REG_ALPHA_GYRO:  prdata = CSR_DATA_W'(gains_ff.alpha_gyro);
         REG_BETA_GYRO:   prdata = CSR_DATA_W'(gains_ff.beta_gyro);
         default:         prdata = '0;
      endcase
   end

endmodule

FILE: sv/scabf_state_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scabf_state_ram
// Per-channel position/velocity store, registered read, with valid bits
// so that unwritten entries read as zero after reset.
// ---------------------------------------------------------------------------
module scabf_state_ram #(
   parameter int DEPTH = 6,
   parameter int AW    = 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic [AW-1:0]                 rd_addr,
   output logic [scabf_pkg::STATE_W-1:0] rd_data,
   input  logic                          wr_en,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [scabf_pkg::STATE_W-1:0] wr_data
);
   import scabf_pkg::*;

   logic [STATE_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]   valid_ff;
   logic [STATE_W-1:0] rd_data_ff;
   logic               rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

FILE: sv/scabf_divider.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scabf_divider
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module scabf_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [scabf_pkg::DIV_NUM_W-1:0] dividend,
   input  logic [scabf_pkg::DT_W-1:0]      divisor,
   output logic                            done,
   output logic [scabf_pkg::DIV_NUM_W-1:0] quotient
);
   import scabf_pkg::*;

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_NUM_W-1:0] quo_ff;
   logic [DT_W-1:0]      rem_ff;
   logic [DT_W-1:0]      dsr_ff;
   logic [DT_W:0]        trial;
   logic [DT_W:0]        diff;
   logic                 ge;

   assign trial = {rem_ff, quo_ff[DIV_NUM_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign ge    = (trial >= {1'b0, dsr_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_W'(DIV_NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DIV_NUM_W-2:0], ge};
         rem_ff <= ge ? diff[DT_W-1:0] : trial[DT_W-1:0];
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: sv/six_channel_alpha_beta_filter.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// six_channel_alpha_beta_filter
// Alpha-beta tracking filter over two groups of sensor channels, state kept
// in a one-port-read, one-port-write memory, arithmetic on a shared
// two-pass multiplier and an iterative divider.
//
//  Channel  Direction  Handshake        Payload
//  req_     in         tvalid/tready    tdata {interval_us, sample}, tuser channel
//  rsp_     out        tvalid/tready    tdata filtered, tuser channel_out
//  csr_     in         APB write/read   gain registers at 0x0, 0x4, 0x8, 0xC
//
// An update runs from accept through the state read, the predict, residual,
// position and beta steps on the multiplier and the bit-serial divider to the
// result; a zero interval or an unused channel goes from the read to the result.
// One transaction is in flight at a time; the next is accepted once the
// result sits in the output register. Reset zeroes all channel state at once.
// A stalled result holds the final step until the output register is free.
// ---------------------------------------------------------------------------
module six_channel_alpha_beta_filter #(
   parameter int CHANNELS_PER_GROUP = 3
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [31:0]                      req_tdata,   // sample, interval_us
   input  logic [scabf_pkg::CHAN_W-1:0]     req_tuser,   // channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [15:0]                      rsp_tdata,   // filtered
   output logic [scabf_pkg::CHAN_W-1:0]     rsp_tuser,   // channel_out
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [scabf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [scabf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [scabf_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                             csr_pready
);
   import scabf_pkg::*;

   localparam int NUM_CH = 2 * CHANNELS_PER_GROUP;
   localparam int AW     = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;
   localparam int CW     = (AW > CHAN_W) ? AW : CHAN_W;
   localparam int XW     = 58;

   localparam logic signed [XW-1:0] POS_MAX_X = (58'sd1 <<< (POS_W - 1)) - 58'sd1;
   localparam logic signed [XW-1:0] POS_MIN_X = -(58'sd1 <<< (POS_W - 1));
   localparam logic signed [XW-1:0] VEL_MAX_X = (58'sd1 <<< (VEL_W - 1)) - 58'sd1;
   localparam logic signed [XW-1:0] VEL_MIN_X = -(58'sd1 <<< (VEL_W - 1));

   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [XW-1:0] v);
      if (v > POS_MAX_X) begin
         sat_pos = POS_MAX_X[POS_W-1:0];
      end else if (v < POS_MIN_X) begin
         sat_pos = POS_MIN_X[POS_W-1:0];
      end else begin
         sat_pos = v[POS_W-1:0];
      end
   endfunction

   function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [XW-1:0] v);
      if (v > VEL_MAX_X) begin
         sat_vel = VEL_MAX_X[VEL_W-1:0];
      end else if (v < VEL_MIN_X) begin
         sat_vel = VEL_MIN_X[VEL_W-1:0];
      end else begin
         sat_vel = v[VEL_W-1:0];
      end
   endfunction

   // truncate toward zero, then clamp to int16
   function automatic logic [15:0] pos_to_out(input logic signed [POS_W-1:0] p);
      logic signed [24:0] i;
      i = 25'(signed'(p[POS_W-1:16])) + 25'(p[POS_W-1] && (p[15:0] != 16'd0));
      if (i > 25'sd32767) begin
         pos_to_out = 16'h7FFF;
      end else if (i < -25'sd32768) begin
         pos_to_out = 16'h8000;
      end else begin
         pos_to_out = i[15:0];
      end
   endfunction

   state_type state_ff, state_in;

   gains_type gains;

   logic [CHAN_W-1:0]          chan_ff;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic [DT_W-1:0]            dt_ff;
   logic                       range_ff;
   logic [ALPHA_W-1:0]         alpha_ff;
   logic [BETA_W-1:0]          beta_ff;
   logic signed [POS_W-1:0]    pos_ff;
   logic signed [VEL_W-1:0]    vel_ff;
   logic signed [POS_W-1:0]    pred_ff;
   logic signed [POS_W-1:0]    r_ff;
   logic [48:0]                acc_ff;
   logic signed [63:0]         prod_ff;
   logic                       neg_ff;

   logic                       rsp_tvalid_ff;
   logic [15:0]                rsp_tdata_ff;
   logic [CHAN_W-1:0]          rsp_tuser_ff;

   logic                       accept;
   logic                       in_range;
   logic                       is_gyro;
   logic [CW-1:0]              req_ch_ext;
   logic [CW-1:0]              chan_ext;
   logic [AW-1:0]              rd_addr;
   logic [STATE_W-1:0]         rd_data;
   logic                       mem_wr;
   logic                       out_free;
   logic                       out_load;
   logic                       div_start;
   logic                       div_done;
   logic [DIV_NUM_W-1:0]       quotient;
   logic [63:0]                prod_mag;

   logic [VEL_W-1:0]           mul_a;
   logic [BETA_W-1:0]          mul_b;
   logic                       mul_lo;
   logic                       mul_hi;
   logic signed [49:0]         hi_prod;
   logic [ALPHA_W-1:0]         alpha_sel;
   logic [BETA_W-1:0]          beta_sel;

   logic signed [XW-1:0]       q_signed;

   // ---- configuration ----
   scabf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .gains   (gains)
   );

   // ---- channel index ----
   assign req_ch_ext = CW'(req_tuser);
   assign chan_ext   = CW'(chan_ff);
   assign in_range   = ({29'd0, req_tuser} < 32'(NUM_CH));
   assign is_gyro    = ({29'd0, chan_ff} >= 32'(CHANNELS_PER_GROUP));
   assign rd_addr    = in_range ? req_ch_ext[AW-1:0] : '0;

   scabf_state_ram #(
      .DEPTH (NUM_CH),
      .AW    (AW)
   ) u_state_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (mem_wr),
      .wr_addr (chan_ext[AW-1:0]),
      .wr_data ({pos_ff, vel_ff})
   );

   // ---- divider: |beta*r| / 256 over interval ----
   assign prod_mag = prod_ff[63] ? 64'(-prod_ff) : 64'(prod_ff);

   scabf_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_mag[63:8]),
      .divisor  (dt_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // ---- shared multiplier, low half then high half ----
   always_comb begin
      case (state_ff)
         ST_PRED_LO, ST_PRED_HI: begin
            mul_a = vel_ff;
            mul_b = BETA_W'(dt_ff);
         end
         ST_POS_LO, ST_POS_HI: begin
            mul_a = VEL_W'(r_ff);
            mul_b = BETA_W'(alpha_ff);
         end
         default: begin
            mul_a = VEL_W'(r_ff);
            mul_b = beta_ff;
         end
      endcase
   end

   assign hi_prod = $signed(mul_a[47:24]) * $signed({1'b0, mul_b});

   assign alpha_sel = is_gyro ? gains.alpha_gyro : gains.alpha_accel;
   assign beta_sel  = is_gyro ? gains.beta_gyro  : gains.beta_accel;

   assign q_signed = neg_ff ? -$signed({2'b00, quotient}) : $signed({2'b00, quotient});

   assign out_free = !rsp_tvalid_ff || rsp_tready;

   // ---- next state ----
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (!range_ff || (dt_ff == '0)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_PRED_LO;
            end
         end
         ST_PRED_LO:   state_in = ST_PRED_HI;
         ST_PRED_HI:   state_in = ST_PRED;
         ST_PRED:      state_in = ST_RESID;
         ST_RESID:     state_in = ST_POS_LO;
         ST_POS_LO:    state_in = ST_POS_HI;
         ST_POS_HI:    state_in = ST_POS;
         ST_POS:       state_in = ST_BETA_LO;
         ST_BETA_LO:   state_in = ST_BETA_HI;
         ST_BETA_HI:   state_in = ST_DIV_START;
         ST_DIV_START: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = ST_VEL;
            end
         end
         ST_VEL:       state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // ---- control outputs ----
   always_comb begin
      req_tready = 1'b0;
      div_start  = 1'b0;
      out_load   = 1'b0;
      mem_wr     = 1'b0;
      mul_lo     = 1'b0;
      mul_hi     = 1'b0;
      case (state_ff)
         ST_IDLE:      req_tready = 1'b1;
         ST_PRED_LO,
         ST_POS_LO,
         ST_BETA_LO:   mul_lo = 1'b1;
         ST_PRED_HI,
         ST_POS_HI,
         ST_BETA_HI:   mul_hi = 1'b1;
         ST_DIV_START: div_start = 1'b1;
         ST_DONE: begin
            out_load = out_free;
            mem_wr   = out_free && range_ff && (dt_ff != '0);
         end
         default: ;
      endcase
   end

   assign accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // ---- datapath ----
   always_ff @(posedge clock) begin
      if (accept) begin
         chan_ff   <= req_tuser;
         sample_ff <= req_tdata[15:0];
         dt_ff     <= req_tdata[31:16];
         range_ff  <= in_range;
      end
      if (state_ff == ST_READ) begin
         pos_ff   <= rd_data[STATE_W-1:VEL_W];
         vel_ff   <= rd_data[VEL_W-1:0];
         alpha_ff <= (alpha_sel > ALPHA_ONE) ? ALPHA_ONE : alpha_sel;
         beta_ff  <= (beta_sel > BETA_ONE) ? BETA_ONE : beta_sel;
      end
      if (mul_lo) begin
         acc_ff <= 49'(mul_a[23:0]) * 49'(mul_b);
      end
      if (mul_hi) begin
         prod_ff <= $signed({hi_prod[39:0], 24'd0} + {15'd0, acc_ff});
      end
      if (state_ff == ST_PRED) begin
         pred_ff <= sat_pos(XW'(pos_ff) + XW'(prod_ff >>> 16));
      end
      if (state_ff == ST_RESID) begin
         r_ff <= sat_pos(XW'($signed({sample_ff, 16'd0})) - XW'(pred_ff));
      end
      if (state_ff == ST_POS) begin
         pos_ff <= sat_pos(XW'(pred_ff) + XW'(prod_ff >>> 16));
      end
      if (div_start) begin
         neg_ff <= prod_ff[63];
      end
      if (state_ff == ST_VEL) begin
         vel_ff <= sat_vel(XW'(vel_ff) + q_signed);
      end
      if (out_load) begin
         rsp_tdata_ff <= range_ff ? pos_to_out(pos_ff) : 16'd0;
         rsp_tuser_ff <= chan_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule
